>>> hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Types, constants and MD5 helpers shared by the sliding window matcher.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_LEN  = 19;
  localparam int OFFSET_BITS = 32;
  localparam int WIN_BITS    = WINDOW_LEN * 8;
  localparam int FILL_W      = $clog2(WINDOW_LEN + 1);
  localparam int MSG_BITS    = WINDOW_LEN * 8;
  localparam int ROUNDS      = 64;
  localparam int CFG_W       = 64;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  typedef enum logic {
    REG_TARGET_LOW  = 1'b0,
    REG_TARGET_HIGH = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       restart;
  } in_word_t;

  typedef struct packed {
    logic        window_ready;
    logic        digest_match;
    logic [31:0] window_start;
  } out_word_t;

  typedef struct packed {
    logic                ready;
    logic [31:0]         start;
    logic [WIN_BITS-1:0] window;
  } work_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] MD5_K [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int MD5_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic int rot_amount(input int i);
    return MD5_ROT[((i / 16) * 4) + (i % 4)];
  endfunction

  function automatic int msg_index(input int i);
    int r;
    r = i / 16;
    if (r == 0) return i;
    else if (r == 1) return ((5 * i) + 1) % 16;
    else if (r == 2) return ((3 * i) + 5) % 16;
    else return (7 * i) % 16;
  endfunction

  function automatic logic [7:0] blk_byte(input logic [WIN_BITS-1:0] window, input int k);
    logic [15:0] bits;
    bits = 16'(MSG_BITS);
    if (k < WINDOW_LEN) return window[8*k +: 8];
    else if (k == WINDOW_LEN) return 8'h80;
    else if (k == 56) return bits[7:0];
    else if (k == 57) return bits[15:8];
    else return 8'h00;
  endfunction

  function automatic logic [31:0] msg_word(input logic [WIN_BITS-1:0] window, input int w);
    return {blk_byte(window, 4*w + 3), blk_byte(window, 4*w + 2),
            blk_byte(window, 4*w + 1), blk_byte(window, 4*w)};
  endfunction

endpackage

>>> hw/rtl/swm_queue.sv
// ----------------------------------------------------------------------------
// swm_queue
// Two-entry queue of classified windows between front and back.
// ----------------------------------------------------------------------------
module swm_queue import swm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  work_t wr_data,
  output logic  full,
  input  logic  rd,
  output logic  valid,
  output work_t rd_data
);

  work_t       mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> hw/rtl/swm_front.sv
// ----------------------------------------------------------------------------
// swm_front
// Window shift line, fill count and stream offset; classifies each byte.
// ----------------------------------------------------------------------------
module swm_front import swm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_word_t in_word,
  output work_t    item
);

  logic [WIN_BITS-1:0]    window;
  logic [FILL_W-1:0]      fill_count;
  logic [OFFSET_BITS-1:0] position;

  logic [FILL_W-1:0]      fill_base;
  logic [OFFSET_BITS-1:0] pos_base;
  logic [FILL_W-1:0]      fill_count_next;
  logic [OFFSET_BITS-1:0] position_next;
  logic [WIN_BITS-1:0]    window_next;
  logic                   saturated;
  logic                   ready;
  logic [OFFSET_BITS-1:0] start_full;

  always_comb begin
    fill_base   = in_word.restart ? '0 : fill_count;
    pos_base    = in_word.restart ? '0 : position;
    window_next = {in_word.text_byte, window[WIN_BITS-1:8]};
    fill_count_next = (fill_base < FILL_W'(WINDOW_LEN)) ? fill_base + 1'b1 : fill_base;
    saturated     = (pos_base == POS_MAX);
    position_next = saturated ? pos_base : pos_base + 1'b1;
    ready         = (fill_count_next >= FILL_W'(WINDOW_LEN));
    if (saturated || position_next == POS_MAX) begin
      start_full = POS_MAX;
    end else begin
      start_full = position_next - OFFSET_BITS'(WINDOW_LEN);
    end
    item.ready  = ready;
    item.start  = ready ? start_full[31:0] : 32'd0;
    item.window = window_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      position   <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      position   <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

endmodule

>>> hw/rtl/swm_back.sv
// ----------------------------------------------------------------------------
// swm_back
// 64-stage MD5 round pipeline, target compare and two-entry result queue.
// ----------------------------------------------------------------------------
module swm_back import swm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  work_t             q_data,
  output logic              q_pop,
  input  logic [CFG_W-1:0]  target_low,
  input  logic [CFG_W-1:0]  target_high,
  input  logic              pop,
  output logic              empty,
  output out_word_t         out_word
);

  logic        v  [ROUNDS+1];
  work_t       wk [ROUNDS+1];
  logic [31:0] sa [ROUNDS+1];
  logic [31:0] sb [ROUNDS+1];
  logic [31:0] sc [ROUNDS+1];
  logic [31:0] sd [ROUNDS+1];

  out_word_t  ofifo [2];
  logic       owr_ptr;
  logic       ord_ptr;
  logic [1:0] ocount;
  logic       en;
  logic       owr;
  logic       ord;
  logic [31:0] fa, fb, fc, fd;
  out_word_t  res;

  assign en    = (ocount != 2'd2);
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ROUNDS; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= q_valid;
      for (int i = 0; i < ROUNDS; i++) begin
        v[i+1] <= v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wk[0] <= q_data;
      sa[0] <= IV_A;
      sb[0] <= IV_B;
      sc[0] <= IV_C;
      sd[0] <= IV_D;
    end
  end

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    localparam int R = i / 16;
    localparam int G = msg_index(i);
    localparam int S = rot_amount(i);
    logic [31:0] f;
    logic [31:0] sum;
    logic [31:0] rot;

    always_comb begin
      if (R == 0) f = (sb[i] & sc[i]) | (~sb[i] & sd[i]);
      else if (R == 1) f = (sd[i] & sb[i]) | (~sd[i] & sc[i]);
      else if (R == 2) f = sb[i] ^ sc[i] ^ sd[i];
      else f = sc[i] ^ (sb[i] | ~sd[i]);
      sum = sa[i] + f + MD5_K[i] + msg_word(wk[i].window, G);
      rot = (sum << S) | (sum >> (32 - S));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wk[i+1] <= wk[i];
        sa[i+1] <= sd[i];
        sd[i+1] <= sc[i];
        sc[i+1] <= sb[i];
        sb[i+1] <= sb[i] + rot;
      end
    end
  end

  always_comb begin
    fa = sa[ROUNDS] + IV_A;
    fb = sb[ROUNDS] + IV_B;
    fc = sc[ROUNDS] + IV_C;
    fd = sd[ROUNDS] + IV_D;
    res.window_ready = wk[ROUNDS].ready;
    res.digest_match = wk[ROUNDS].ready && ({fb, fa} == target_low)
                       && ({fd, fc} == target_high);
    res.window_start = wk[ROUNDS].start;
  end

  assign owr      = en && v[ROUNDS];
  assign empty    = (ocount == 2'd0);
  assign ord      = pop && !empty;
  assign out_word = ofifo[ord_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= 1'b0;
      ord_ptr <= 1'b0;
      ocount  <= 2'd0;
    end else begin
      if (owr) begin
        owr_ptr <= ~owr_ptr;
      end
      if (ord) begin
        ord_ptr <= ~ord_ptr;
      end
      ocount <= ocount + {1'b0, owr} - {1'b0, ord};
    end
  end

  always_ff @(posedge clk) begin
    if (owr) begin
      ofifo[owr_ptr] <= res;
    end
  end

endmodule

>>> hw/rtl/sliding_window_md5_matcher.sv
// Sliding window MD5 matcher: push one text byte per word; every byte gives one
// result word holding window_ready, digest_match and the offset of the window's
// first byte once 19 bytes are held. One byte is taken every cycle while the
// window queue is not full. A result word passes through the window queue, the
// pipeline input register, the 64 MD5 round stages (one round per stage) and the
// result queue before it can be popped; a full result queue holds the whole round
// pipeline until a word is popped.
// ----------------------------------------------------------------------------
// sliding_window_md5_matcher
// Top level: config registers, front, window queue and MD5 back end.
// ----------------------------------------------------------------------------
module sliding_window_md5_matcher import swm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_word_t         in_word,
  output logic             empty,
  input  logic             pop,
  output out_word_t        out_word,
  input  logic             cfg_write,
  input  reg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] target_low;
  logic [CFG_W-1:0] target_high;
  logic             accept;
  work_t            f_item;
  logic             q_valid;
  work_t            q_data;
  logic             q_pop;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_low  <= '0;
      target_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARGET_LOW:  target_low  <= cfg_data;
        REG_TARGET_HIGH: target_high <= cfg_data;
        default: ;
      endcase
    end
  end

  swm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (in_word),
    .item    (f_item)
  );

  swm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (f_item),
    .full    (full),
    .rd      (q_pop),
    .valid   (q_valid),
    .rd_data (q_data)
  );

  swm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .target_low  (target_low),
    .target_high (target_high),
    .pop         (pop),
    .empty       (empty),
    .out_word    (out_word)
  );

  a_pop_has_word: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("back end took a word from an empty queue");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_word.window_ready) |-> (!out_word.digest_match
                                            && out_word.window_start == 32'd0))
    else $error("result without full window carries match or offset");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (full && !q_pop) |=> full)
    else $error("queue full dropped without a pop");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams text bytes through the sliding window MD5 matcher under several
// flow-control phases and target digests, and checks every result word
// against a cycle-free MD5 window predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import swm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 200;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  in_word_t         in_word;
  logic             empty;
  logic             pop;
  out_word_t        out_word;
  logic             cfg_write;
  reg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  sliding_window_md5_matcher DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  in_word_t  byte_queue[$];
  out_word_t result_queue[$];
  logic [7:0]  text_window[WINDOW_LEN];
  int          fill_level;
  logic [32:0] stream_pos;
  logic [63:0] target_lo, target_hi;
  int          errors;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [127:0] window_digest();
    logic [7:0]  blk[64];
    logic [31:0] m[16];
    logic [31:0] a, b, c, d, f, t, s;
    int          g;
    int          r;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < WINDOW_LEN; i++) blk[i] = text_window[i];
    blk[WINDOW_LEN] = 8'h80;
    blk[56] = 8'(WINDOW_LEN * 8);
    blk[57] = 8'((WINDOW_LEN * 8) >> 8);
    for (int i = 0; i < 16; i++) m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; c = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (d & b) | (~d & c); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      s = a + f + MD5_K[i] + m[g];
      t = d; d = c; c = b;
      b = b + ((s << MD5_ROT[r*4 + i%4]) | (s >> (32 - MD5_ROT[r*4 + i%4])));
      a = t;
    end
    a += 32'h67452301; b += 32'hefcdab89; c += 32'h98badcfe; d += 32'h10325476;
    return {d, c, b, a};
  endfunction

  function automatic out_word_t predict_result(in_word_t w);
    out_word_t   res;
    logic [127:0] dg;
    logic         sat;
    res = '0;
    if (w.restart) begin
      for (int i = 0; i < WINDOW_LEN; i++) text_window[i] = 8'h00;
      fill_level = 0;
      stream_pos = '0;
    end
    if (fill_level < WINDOW_LEN) begin
      text_window[fill_level] = w.text_byte;
      fill_level++;
    end else begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) text_window[i] = text_window[i+1];
      text_window[WINDOW_LEN-1] = w.text_byte;
    end
    sat = stream_pos >= 33'hFFFF_FFFF;
    if (!sat) stream_pos++;
    if (fill_level >= WINDOW_LEN) begin
      dg = window_digest();
      res.window_ready = 1'b1;
      res.digest_match = (dg[63:0] == target_lo) && (dg[127:64] == target_hi);
      if (sat || stream_pos >= 33'hFFFF_FFFF) res.window_start = 32'hFFFF_FFFF;
      else res.window_start = 32'(stream_pos - WINDOW_LEN);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        result_queue.push_back(predict_result(in_word));
        void'(byte_queue.pop_front());
      end
      if ((!push || !full) && !(push && !full && byte_queue.size() == 0)) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_word <= byte_queue[0];
        end else begin
          push <= 1'b0;
        end
      end else if (push && !full) begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (result_queue.size() == 0) begin
          $display("unexpected result word at cycle %0d", cycle_count);
          errors++;
        end else begin
          if (out_word.window_ready !== result_queue[0].window_ready)
            report_mismatch("window_ready", 32'(out_word.window_ready),
                            32'(result_queue[0].window_ready));
          if (out_word.digest_match !== result_queue[0].digest_match)
            report_mismatch("digest_match", 32'(out_word.digest_match),
                            32'(result_queue[0].digest_match));
          if (out_word.window_start !== result_queue[0].window_start)
            report_mismatch("window_start", out_word.window_start,
                            result_queue[0].window_start);
          void'(result_queue.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TARGET_LOW) target_lo = val;
    else target_hi = val;
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || push || result_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(logic [7:0] b, logic rs);
    in_word_t w;
    w.text_byte = b;
    w.restart   = rs;
    byte_queue.push_back(w);
  endtask

  // Build a window whose digest the target then matches.
  task automatic arm_match_on(logic [7:0] seed[WINDOW_LEN]);
    logic [127:0] dg;
    for (int i = 0; i < WINDOW_LEN; i++) text_window[i] = seed[i];
    dg = window_digest();
    write_reg(REG_TARGET_LOW, dg[63:0]);
    write_reg(REG_TARGET_HIGH, dg[127:64]);
  endtask

  initial begin
    logic [7:0] seed[WINDOW_LEN];
    logic [7:0] saved_win[WINDOW_LEN];
    int         saved_fill;
    logic [32:0] saved_pos;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    in_word = '0;
    cfg_write = 1'b0;
    cfg_index = REG_TARGET_LOW;
    cfg_data = '0;
    errors = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    target_lo = '0;
    target_hi = '0;
    for (int i = 0; i < WINDOW_LEN; i++) text_window[i] = 8'h00;
    fill_level = 0;
    stream_pos = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: all-zero window, then extremes, with matching targets
    for (int i = 0; i < WINDOW_LEN; i++) seed[i] = 8'h00;
    arm_match_on(seed);
    for (int i = 0; i < WINDOW_LEN; i++) text_window[i] = 8'h00;
    for (int i = 0; i < WINDOW_LEN; i++) queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hA5, 1'b1);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'hFF, 1'b1);
    drain();

    for (int i = 0; i < WINDOW_LEN; i++) seed[i] = 8'hFF;
    saved_win = text_window; saved_fill = fill_level; saved_pos = stream_pos;
    arm_match_on(seed);
    text_window = saved_win; fill_level = saved_fill; stream_pos = saved_pos;
    for (int i = 0; i < WINDOW_LEN + 3; i++) queue_byte(8'hFF, 1'b0);
    drain();

    // random phases; phases 0-2 target a seed window that may appear
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int i = 0; i < WINDOW_LEN; i++) seed[i] = 8'($urandom);
      saved_win = text_window; saved_fill = fill_level; saved_pos = stream_pos;
      if (ph == 3) begin
        write_reg(REG_TARGET_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_TARGET_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      end else begin
        arm_match_on(seed);
      end
      text_window = saved_win; fill_level = saved_fill; stream_pos = saved_pos;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(9) == 0) begin
          for (int i = 0; i < WINDOW_LEN; i++) queue_byte(seed[i], i == 0);
          n += WINDOW_LEN;
        end else begin
          queue_byte(8'($urandom), $urandom_range(29) == 0);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
